### hw/rtl/dtir_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the door and trip interval recorder.
package dtir_pkg;

    // Field widths fixed by the item format
    localparam int DECK_W  = 3;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 32;
    localparam int FLOOR_W = 8;
    localparam int SHAFT_W = 16;

    // Opcodes of an input item
    localparam logic [1:0] OP_START_RUN = 2'd0;
    localparam logic [1:0] OP_DOOR      = 2'd1;
    localparam logic [1:0] OP_CAR       = 2'd2;

    // Door modes
    localparam logic [1:0] DS_CLOSED  = 2'd0;
    localparam logic [1:0] DS_OPENING = 2'd1;
    localparam logic [1:0] DS_OPEN    = 2'd2;
    localparam logic [1:0] DS_CLOSING = 2'd3;

    // Car modes
    localparam logic [1:0] CAR_STOPPED = 2'd0;
    localparam logic [1:0] CAR_MOVING  = 2'd1;
    localparam logic [1:0] CAR_SHAFT   = 2'd2;

    // Record kinds
    localparam logic KIND_DOOR = 1'b0;
    localparam logic KIND_TRIP = 1'b1;

    // Trip numbering: id kept as block count and offset inside the block
    localparam int TRIP_BLOCK = 1000;
    localparam int BLK_W      = 23;
    localparam int OFS_W      = 10;
    // Largest block count a 32-bit id can reach, (2^32 - 1) / 1000
    localparam logic [BLK_W-1:0] BLK_MAX  = 23'd4294967;
    localparam logic [OFS_W-1:0] OFS_LAST = 10'(TRIP_BLOCK - 1);
    // Id after renumbering from the top block wraps: (BLK_MAX + 1) * 1000 - 2^32
    localparam logic [OFS_W-1:0] WRAP_OFS = 10'd704;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    journey;
        logic [DECK_W-1:0]  deck;
        logic [TIME_W-1:0]  st;
        logic [TIME_W-1:0]  et;
        logic [FLOOR_W-1:0] ff;
        logic [FLOOR_W-1:0] ft;
        logic [SHAFT_W-1:0] shaft;
        logic               miss;
        logic               last;
    } rec_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] lct;
        logic [TIME_W-1:0] pot;
        logic              pov;
    } deck_entry_t;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [DECK_W-1:0] rd_addr;
        logic              wr_en;
        logic [DECK_W-1:0] wr_addr;
        deck_entry_t       wr_entry;
    } mem_req_t;

    typedef struct packed {
        logic renum;
        logic adv;
    } trip_ctl_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } push_t;

endpackage

### hw/rtl/dtir_deck_mem.sv
`timescale 1ns / 1ps
// Per-deck door state memory with registered read data and per-entry valid bits.
module dtir_deck_mem #(
    parameter int DECKS = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtir_pkg::mem_req_t   req,
    output dtir_pkg::deck_entry_t rd_entry
);
    import dtir_pkg::*;

    localparam int DAW = (DECKS > 1) ? $clog2(DECKS) : 1;

    deck_entry_t            mem [DECKS];
    deck_entry_t            rd_data_reg;
    logic                   rd_vld_reg;
    logic [DECKS-1:0]       vld_reg;
    logic [DECKS-1:0]       vld_next;
    deck_entry_t            reset_entry;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[DAW-1:0]] <= req.wr_entry;
        end
    end

    // Registered read data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[DAW-1:0]];
        end
    end

    // Track which entries hold written data; clear drops all of them
    always_comb
    begin
        vld_next = vld_reg;
        if (req.clear)
        begin
            vld_next = '0;
        end
        else if (req.wr_en)
        begin
            vld_next[req.wr_addr[DAW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr[DAW-1:0]];
            end
        end
    end

    // An unwritten entry reads as a closed door with no pending open
    always_comb
    begin
        reset_entry      = rd_data_reg;
        reset_entry.mode = DS_CLOSED;
        reset_entry.lct  = '0;
        reset_entry.pov  = 1'b0;
        rd_entry         = rd_vld_reg ? rd_data_reg : reset_entry;
    end

endmodule

### hw/rtl/dtir_trip_ctr.sv
`timescale 1ns / 1ps
// Trip id counter with block renumbering, kept as block count plus offset.
module dtir_trip_ctr (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dtir_pkg::trip_ctl_t       ctl,
    output logic [dtir_pkg::ID_W-1:0] current_id
);
    import dtir_pkg::*;

    logic [ID_W-1:0]  cur_reg;
    logic [ID_W-1:0]  cur_next;
    logic [ID_W-1:0]  nid_reg;
    logic [ID_W-1:0]  nid_next;
    logic [BLK_W-1:0] blk_reg;
    logic [BLK_W-1:0] blk_next;
    logic [OFS_W-1:0] ofs_reg;
    logic [OFS_W-1:0] ofs_next;

    // Renumber to the next block, or advance the current trip
    always_comb
    begin
        cur_next = cur_reg;
        nid_next = nid_reg;
        blk_next = blk_reg;
        ofs_next = ofs_reg;
        if (ctl.renum)
        begin
            if (blk_reg == BLK_MAX)
            begin
                nid_next = ID_W'(WRAP_OFS);
                blk_next = '0;
                ofs_next = WRAP_OFS;
            end
            else
            begin
                nid_next = nid_reg - ID_W'(ofs_reg) + ID_W'(TRIP_BLOCK);
                blk_next = blk_reg + 1'b1;
                ofs_next = '0;
            end
        end
        else if (ctl.adv)
        begin
            cur_next = nid_reg;
            if (nid_reg == '1)
            begin
                nid_next = '0;
                blk_next = '0;
                ofs_next = '0;
            end
            else
            begin
                nid_next = nid_reg + 1'b1;
                if (ofs_reg == OFS_LAST)
                begin
                    ofs_next = '0;
                    blk_next = blk_reg + 1'b1;
                end
                else
                begin
                    ofs_next = ofs_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            nid_reg <= '0;
            blk_reg <= '0;
            ofs_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            nid_reg <= nid_next;
            blk_reg <= blk_next;
            ofs_reg <= ofs_next;
        end
    end

    assign current_id = cur_reg;

endmodule

### hw/rtl/dtir_seq.sv
`timescale 1ns / 1ps
// Item sequencer: reads, updates and writes back deck state and builds records.
module dtir_seq #(
    parameter int DECKS = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [1:0]                   opcode,
    input  logic [dtir_pkg::TIME_W-1:0]  event_time,
    input  logic [dtir_pkg::DECK_W-1:0]  deck,
    input  logic [1:0]                   door_state,
    input  logic [1:0]                   car_state,
    input  logic [dtir_pkg::FLOOR_W-1:0] floor_current,
    input  logic [dtir_pkg::FLOOR_W-1:0] floor_destination,
    input  logic [dtir_pkg::SHAFT_W-1:0] lift_id,
    input  logic [dtir_pkg::ID_W-1:0]    current_id,
    input  dtir_pkg::deck_entry_t        rd_entry,
    input  logic                         out_free,
    output logic                         busy,
    output dtir_pkg::mem_req_t           mem_req,
    output dtir_pkg::trip_ctl_t          trip_ctl,
    output dtir_pkg::push_t              push
);
    import dtir_pkg::*;

    localparam int DAW = (DECKS > 1) ? $clog2(DECKS) : 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RENUM  = 8'b0000_0010,
        S_ADV    = 8'b0000_0100,
        S_D_HALF = 8'b0000_1000,
        S_D_WB   = 8'b0001_0000,
        S_C_DEC  = 8'b0010_0000,
        S_C_WB   = 8'b0100_0000,
        S_FLUSH  = 8'b1000_0000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [TIME_W-1:0]   t_reg;
    logic [DECK_W-1:0]   deck_reg;
    logic [1:0]          ds_reg;
    logic [1:0]          cs_reg;
    logic [FLOOR_W-1:0]  fcur_reg;
    logic [FLOOR_W-1:0]  fdest_reg;
    logic [TIME_W-1:0]   half_reg;
    logic [TIME_W-1:0]   half_next;
    logic [1:0]          car_mode_reg;
    logic [1:0]          car_mode_next;
    logic [FLOOR_W-1:0]  trip_from_reg;
    logic [FLOOR_W-1:0]  trip_from_next;
    logic [TIME_W-1:0]   trip_go_reg;
    logic [TIME_W-1:0]   trip_go_next;
    logic [DAW-1:0]      d_reg;
    logic [DAW-1:0]      d_next;
    rec_t                pend_reg;
    rec_t                pend_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic                deck_ok;
    logic [1:0]          cs_norm;
    rec_t                rec_base;
    deck_entry_t         upd;
    logic                emit;
    logic                stall_push;
    logic [TIME_W-1:0]   t_split;

    assign deck_ok  = ({1'b0, deck} < 4'(DECKS));
    assign cs_norm  = (car_state == CAR_MOVING || car_state == CAR_SHAFT) ?
                      car_state : CAR_STOPPED;
    assign t_split  = t_reg - half_reg;
    assign busy     = (state_reg != S_IDLE);

    // Common record fields
    always_comb
    begin
        rec_base         = '0;
        rec_base.journey = current_id;
        rec_base.shaft   = lift_id;
    end

    always_comb
    begin
        state_next      = state_reg;
        half_next       = half_reg;
        car_mode_next   = car_mode_reg;
        trip_from_next  = trip_from_reg;
        trip_go_next    = trip_go_reg;
        d_next          = d_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        mem_req         = '0;
        trip_ctl        = '0;
        push            = '0;
        upd             = rd_entry;
        emit            = 1'b0;
        stall_push      = 1'b0;

        unique case (state_reg)
            // Take an item and route it
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_START_RUN:
                        begin
                            state_next = S_RENUM;
                        end
                        OP_DOOR:
                        begin
                            if (deck_ok)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = deck;
                                state_next      = S_D_HALF;
                            end
                        end
                        OP_CAR:
                        begin
                            state_next = S_C_DEC;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Renumber trips, close every door and set the car stopped
            S_RENUM:
            begin
                trip_ctl.renum = 1'b1;
                mem_req.clear  = 1'b1;
                car_mode_next  = CAR_STOPPED;
                state_next     = S_ADV;
            end

            S_ADV:
            begin
                trip_ctl.adv = 1'b1;
                state_next   = S_IDLE;
            end

            // Split the time since the last change in half
            S_D_HALF:
            begin
                half_next  = (t_reg - rd_entry.lct) >> 1;
                state_next = S_D_WB;
            end

            // Update one door and build its record
            S_D_WB:
            begin
                pend_next          = rec_base;
                pend_next.kind     = KIND_DOOR;
                pend_next.deck     = deck_reg;
                pend_next.st       = rd_entry.pov ? rd_entry.pot : '0;
                pend_next.miss     = !rd_entry.pov;
                pend_next.et       = rd_entry.lct;
                unique case (ds_reg)
                    DS_CLOSED:
                    begin
                        emit    = 1'b1;
                        upd.pov = 1'b0;
                        if (rd_entry.mode == DS_OPENING)
                        begin
                            pend_next.st   = rd_entry.lct;
                            pend_next.miss = 1'b0;
                            pend_next.et   = t_split;
                        end
                        else if (rd_entry.mode != DS_CLOSING)
                        begin
                            pend_next.et = t_reg;
                        end
                    end
                    DS_OPENING:
                    begin
                        if (rd_entry.mode == DS_CLOSING)
                        begin
                            emit    = 1'b1;
                            upd.pov = 1'b0;
                        end
                    end
                    DS_OPEN:
                    begin
                        upd.pov = 1'b1;
                        if (rd_entry.mode == DS_OPENING)
                        begin
                            upd.pot = rd_entry.lct;
                        end
                        else if (rd_entry.mode == DS_CLOSING)
                        begin
                            emit    = 1'b1;
                            upd.pot = t_split;
                        end
                        else
                        begin
                            upd.pot = t_reg;
                        end
                    end
                    default:
                    begin
                        if (rd_entry.mode == DS_OPENING)
                        begin
                            upd.pot = rd_entry.lct;
                            upd.pov = 1'b1;
                        end
                    end
                endcase
                upd.mode = ds_reg;
                upd.lct  = t_reg;
                if (ds_reg != rd_entry.mode)
                begin
                    mem_req.wr_en    = 1'b1;
                    mem_req.wr_addr  = deck_reg;
                    mem_req.wr_entry = upd;
                    pend_valid_next  = emit;
                end
                state_next = S_FLUSH;
            end

            // Car mode change: close the open trip, start door sweep on moves
            S_C_DEC:
            begin
                pend_next      = rec_base;
                pend_next.kind = KIND_TRIP;
                pend_next.st   = trip_go_reg;
                pend_next.et   = t_reg;
                pend_next.ff   = trip_from_reg;
                if (cs_reg == car_mode_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (cs_reg == CAR_STOPPED)
                begin
                    pend_next.ft    = fcur_reg;
                    pend_valid_next = 1'b1;
                    trip_ctl.adv    = 1'b1;
                    car_mode_next   = CAR_STOPPED;
                    state_next      = S_FLUSH;
                end
                else
                begin
                    pend_next.ft = fdest_reg;
                    if (car_mode_reg != CAR_STOPPED)
                    begin
                        pend_valid_next = 1'b1;
                        trip_ctl.adv    = 1'b1;
                    end
                    trip_from_next  = fcur_reg;
                    trip_go_next    = t_reg;
                    car_mode_next   = cs_reg;
                    d_next          = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                    state_next      = S_C_WB;
                end
            end

            // Sweep decks: close closing doors, latch opening doors
            S_C_WB:
            begin
                emit       = (rd_entry.mode == DS_CLOSING);
                stall_push = emit && pend_valid_reg && !out_free;
                upd.mode   = DS_CLOSED;
                if (rd_entry.mode == DS_CLOSING)
                begin
                    upd.pov = 1'b0;
                end
                else if (rd_entry.mode == DS_OPENING)
                begin
                    upd.pot = rd_entry.lct;
                    upd.pov = 1'b1;
                end
                if (!stall_push)
                begin
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            push.valid    = 1'b1;
                            push.rec      = pend_reg;
                            push.rec.last = 1'b0;
                        end
                        pend_next       = rec_base;
                        pend_next.kind  = KIND_DOOR;
                        pend_next.deck  = DECK_W'(d_reg);
                        pend_next.st    = rd_entry.pov ? rd_entry.pot : '0;
                        pend_next.miss  = !rd_entry.pov;
                        pend_next.et    = rd_entry.lct;
                        pend_valid_next = 1'b1;
                    end
                    mem_req.wr_en    = 1'b1;
                    mem_req.wr_addr  = DECK_W'(d_reg);
                    mem_req.wr_entry = upd;
                    if (d_reg == DAW'(DECKS - 1))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        d_next          = d_reg + 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = DECK_W'(d_next);
                    end
                end
            end

            // Hand off the held record as the last one of the item
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push.valid      = 1'b1;
                    push.rec        = pend_reg;
                    push.rec.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            car_mode_reg   <= CAR_STOPPED;
            pend_valid_reg <= 1'b0;
            d_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            car_mode_reg   <= car_mode_next;
            pend_valid_reg <= pend_valid_next;
            d_reg          <= d_next;
        end
    end

    // Item latch and payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg     <= event_time;
            deck_reg  <= deck;
            ds_reg    <= door_state;
            cs_reg    <= cs_norm;
            fcur_reg  <= floor_current;
            fdest_reg <= floor_destination;
        end
        half_reg      <= half_next;
        trip_from_reg <= trip_from_next;
        trip_go_reg   <= trip_go_next;
        pend_reg      <= pend_next;
    end

endmodule

### hw/rtl/door_and_trip_interval_recorder.sv
`timescale 1ns / 1ps
// Top level of the door and trip interval recorder.
//
// Input channel (in_valid / in_stall): one time-ordered lift event per item:
// start run, door event for one deck, or car event. Output channel
// (out_valid / out_stall): door cycle and trip records, up to 1 + DECKS per
// item, the final one of an item marked by last. Configuration channel
// (cfg_valid / cfg_ready / cfg_data) writes lift_id; write it only while idle.
// Each item runs through a sequencer that reads a deck entry from the deck
// state memory, updates it and writes it back. A door event on a valid deck
// holds the input through read, half-interval, update and hand-off, its record
// entering the output register at hand-off; a car move through decode, a sweep
// of every deck through the memory port and hand-off; a car stop through decode
// and hand-off, a start run through renumbering and trip advance, a repeated car
// mode through decode only, and an unused opcode or a deck out of range not at
// all. The output register lets the next item enter while the last record still
// waits. When the receiver stalls, records hold in the output register and the
// sequencer waits; in_stall stays high until the item is done. Reset clears all
// door state, car mode, trip numbering and lift_id, with no clearing pass.
module door_and_trip_interval_recorder #(
    parameter int DECKS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] event_time,
    input  logic [2:0]  deck,
    input  logic [1:0]  door_state,
    input  logic [1:0]  car_state,
    input  logic [7:0]  floor_current,
    input  logic [7:0]  floor_destination,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        record_kind,
    output logic [31:0] journey_id,
    output logic [2:0]  deck_out,
    output logic [31:0] start_time,
    output logic [31:0] end_time,
    output logic [7:0]  floor_from,
    output logic [7:0]  floor_to,
    output logic [15:0] shaft,
    output logic        open_missing,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import dtir_pkg::*;

    logic               busy;
    logic               accept;
    logic               out_free;
    logic [SHAFT_W-1:0] lift_id_reg;
    logic [ID_W-1:0]    current_id;
    mem_req_t           mem_req;
    deck_entry_t        rd_entry;
    trip_ctl_t          trip_ctl;
    push_t              push;
    logic               out_valid_reg;
    rec_t               out_rec_reg;

    assign in_stall  = busy;
    assign accept    = in_valid && !busy;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // Hold the lift identifier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lift_id_reg <= cfg_data;
        end
    end

    dtir_deck_mem #(
        .DECKS (DECKS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    dtir_trip_ctr u_trip (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (trip_ctl),
        .current_id (current_id)
    );

    dtir_seq #(
        .DECKS (DECKS)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .opcode            (opcode),
        .event_time        (event_time),
        .deck              (deck),
        .door_state        (door_state),
        .car_state         (car_state),
        .floor_current     (floor_current),
        .floor_destination (floor_destination),
        .lift_id           (lift_id_reg),
        .current_id        (current_id),
        .rd_entry          (rd_entry),
        .out_free          (out_free),
        .busy              (busy),
        .mem_req           (mem_req),
        .trip_ctl          (trip_ctl),
        .push              (push)
    );

    // Output register: load a pushed item, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_rec_reg <= push.rec;
        end
    end

    assign out_valid    = out_valid_reg;
    assign record_kind  = out_rec_reg.kind;
    assign journey_id   = out_rec_reg.journey;
    assign deck_out     = out_rec_reg.deck;
    assign start_time   = out_rec_reg.st;
    assign end_time     = out_rec_reg.et;
    assign floor_from   = out_rec_reg.ff;
    assign floor_to     = out_rec_reg.ft;
    assign shaft        = out_rec_reg.shaft;
    assign open_missing = out_rec_reg.miss;
    assign last         = out_rec_reg.last;

endmodule
